// File: rtl/core/ffcc_pkg.sv
// ----------------------------------------------------------------------------
// ffcc_pkg
// Shared types, constants and helpers of the FAT free-cluster counter.
// ----------------------------------------------------------------------------
package ffcc_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Entry index saturates here
	localparam logic [16:0] POS_MAX = 17'h1FFFF;
	// Largest cluster count that still uses 12-bit entries
	localparam logic [15:0] FAT12_LIMIT = 16'd4084;
	// Root directory entries are 32 bytes
	localparam int unsigned DIR_ENTRY_LOG2 = 5;
	localparam logic [3:0]  SECTOR_LOG2_MIN = 4'd9;
	localparam logic [3:0]  SECTOR_LOG2_MAX = 4'd12;
	localparam logic [15:0] TALLY_MAX = 16'hFFFF;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SECTOR_LOG2  = 3'd0,
		CFG_CLUSTER_LOG2 = 3'd1,
		CFG_RESERVED     = 3'd2,
		CFG_FAT_COPIES   = 3'd3,
		CFG_FAT_SECTORS  = 3'd4,
		CFG_ROOT_LIMIT   = 3'd5,
		CFG_VOL_SECTORS  = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_EMPTY = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [3:0]  sector_bytes_log2;
		logic [2:0]  cluster_sectors_log2;
		logic [15:0] reserved_count;
		logic [7:0]  fat_copies;
		logic [15:0] fat_sectors;
		logic [15:0] root_entry_limit;
		logic [15:0] volume_sectors;
	} cfg_t;

	typedef struct packed {
		logic [15:0] clusters;
		logic        twelve_bit;
	} geom_t;

	function automatic logic [3:0] clamp_sl(input logic [3:0] raw);
		logic [3:0] res;
		res = raw;
		if (raw < SECTOR_LOG2_MIN) res = SECTOR_LOG2_MIN;
		if (raw > SECTOR_LOG2_MAX) res = SECTOR_LOG2_MAX;
		return res;
	endfunction

endpackage

// File: rtl/core/ffcc_geom.sv
// ----------------------------------------------------------------------------
// ffcc_geom
// Two-stage volume geometry: data cluster count and FAT entry width.
// ----------------------------------------------------------------------------
module ffcc_geom (
	input  logic           clk,
	input  logic           arst_n,
	input  ffcc_pkg::cfg_t cfg,
	output ffcc_pkg::geom_t geom
);

	logic [3:0]  sl;
	logic [21:0] root_mask;
	logic [21:0] root_bytes;
	logic [21:0] root_shift;
	logic [23:0] prod_q;
	logic [16:0] rsv_root_q;
	logic [24:0] used;
	logic [15:0] area_secs;
	logic [15:0] clusters;
	logic [15:0] clusters_q;
	logic        twelve_q;

	// first stage: FAT area, and reserved plus root directory sectors (rounded up)
	always_comb begin
		sl         = ffcc_pkg::clamp_sl(cfg.sector_bytes_log2);
		root_mask  = (22'd1 << sl) - 22'd1;
		root_bytes = {1'b0, cfg.root_entry_limit, 5'b0} + root_mask;
		root_shift = root_bytes >> sl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q     <= '0;
			rsv_root_q <= '0;
		end else begin
			prod_q     <= cfg.fat_copies * cfg.fat_sectors;
			rsv_root_q <= {1'b0, cfg.reserved_count} + {4'b0, root_shift[12:0]};
		end
	end

	// second stage: data area, clamped at zero, then scaled to clusters
	always_comb begin
		used = {1'b0, prod_q} + {8'b0, rsv_root_q};
		if (used >= {9'b0, cfg.volume_sectors}) begin
			area_secs = '0;
		end else begin
			area_secs = cfg.volume_sectors - used[15:0];
		end
		clusters = area_secs >> cfg.cluster_sectors_log2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= '0;
			twelve_q   <= 1'b1;
		end else begin
			clusters_q <= clusters;
			twelve_q   <= (clusters <= ffcc_pkg::FAT12_LIMIT);
		end
	end

	assign geom.clusters   = clusters_q;
	assign geom.twelve_bit = twelve_q;

endmodule

// File: rtl/core/ffcc_tally.sv
// ----------------------------------------------------------------------------
// ffcc_tally
// Unpacks FAT12/FAT16 entries from the byte stream and counts free ones.
// ----------------------------------------------------------------------------
module ffcc_tally (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      table_byte,
	input  logic            final_byte,
	input  ffcc_pkg::geom_t geom,
	output logic [15:0]     tally_next
);

	ffcc_pkg::phase_t phase_q, phase_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  second_q, second_d;
	logic [16:0] pos_q, pos_d;
	logic [15:0] tally_q;
	logic [16:0] pos_b, pos_c;
	logic [16:0] limit;
	logic        range_a, range_b;
	logic        hit_a, hit_b;
	logic [15:0] tally_a;

	always_comb begin
		pos_b   = (pos_q == ffcc_pkg::POS_MAX) ? pos_q : pos_q + 17'd1;
		pos_c   = (pos_b == ffcc_pkg::POS_MAX) ? pos_b : pos_b + 17'd1;
		limit   = {1'b0, geom.clusters} + 17'd2;
		range_a = (pos_q >= 17'd2) && (pos_q < limit);
		range_b = (pos_b >= 17'd2) && (pos_b < limit);

		phase_d  = phase_q;
		first_d  = first_q;
		second_d = second_q;
		pos_d    = pos_q;
		hit_a    = 1'b0;
		hit_b    = 1'b0;

		if (geom.twelve_bit) begin
			case (phase_q)
				ffcc_pkg::PH_EMPTY: begin
					first_d = table_byte;
					phase_d = ffcc_pkg::PH_ONE;
				end
				ffcc_pkg::PH_ONE: begin
					second_d = table_byte;
					phase_d  = ffcc_pkg::PH_TWO;
				end
				default: begin
					// group complete: two 12-bit entries
					hit_a   = (first_q == 8'd0) && (second_q[3:0] == 4'd0) && range_a;
					hit_b   = (second_q[7:4] == 4'd0) && (table_byte == 8'd0) && range_b;
					pos_d   = pos_c;
					phase_d = ffcc_pkg::PH_EMPTY;
				end
			endcase
		end else begin
			case (phase_q)
				ffcc_pkg::PH_EMPTY: begin
					first_d = table_byte;
					phase_d = ffcc_pkg::PH_ONE;
				end
				default: begin
					hit_a   = (first_q == 8'd0) && (table_byte == 8'd0) && range_a;
					pos_d   = pos_b;
					phase_d = ffcc_pkg::PH_EMPTY;
				end
			endcase
		end

		tally_a    = (hit_a && tally_q != ffcc_pkg::TALLY_MAX) ? tally_q + 16'd1 : tally_q;
		tally_next = (hit_b && tally_a != ffcc_pkg::TALLY_MAX) ? tally_a + 16'd1 : tally_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ffcc_pkg::PH_EMPTY;
			first_q  <= '0;
			second_q <= '0;
			pos_q    <= '0;
			tally_q  <= '0;
		end else if (take) begin
			if (final_byte) begin
				phase_q  <= ffcc_pkg::PH_EMPTY;
				first_q  <= '0;
				second_q <= '0;
				pos_q    <= '0;
				tally_q  <= '0;
			end else begin
				phase_q  <= phase_d;
				first_q  <= first_d;
				second_q <= second_d;
				pos_q    <= pos_d;
				tally_q  <= tally_next;
			end
		end
	end

endmodule

// File: rtl/core/fat_free_cluster_counter_unit.sv
// Path: a final byte passes the input register, then the second stage, then the counter
// update into the result register, where out_valid rises.
// Throughput: one byte per cycle while in_stall is low.
// The result register lets bytes other than a final byte keep flowing while a result waits.
// Reset: asynchronous, active low; counters clear and config registers load
// their defaults (512-byte sectors, 1440 KB floppy geometry).
// ----------------------------------------------------------------------------
// fat_free_cluster_counter_unit
// Counts free clusters in a streamed FAT12/FAT16 table and reports the
// volume's free space, cluster count, table width and size.
// ----------------------------------------------------------------------------
module fat_free_cluster_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  table_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] free_clusters,
	output logic [34:0] free_bytes,
	output logic [15:0] cluster_count,
	output logic        twelve_bit_table,
	output logic [27:0] disk_bytes
);

	ffcc_pkg::cfg_t  cfg_q;
	ffcc_pkg::geom_t geom;

	logic       v_s1, last_s1;
	logic [7:0] byte_s1;
	logic       v_s2, last_s2;
	logic [7:0] byte_s2;
	logic       out_free, s2_move, en1, take;
	logic [15:0] tally_next;
	logic [3:0]  sl;
	logic [4:0]  shift_total;

	logic        out_valid_q;
	logic [15:0] free_clusters_q;
	logic [34:0] free_bytes_q;
	logic [15:0] cluster_count_q;
	logic        twelve_q;
	logic [27:0] disk_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sector_bytes_log2    <= 4'd9;
			cfg_q.cluster_sectors_log2 <= 3'd0;
			cfg_q.reserved_count       <= 16'd1;
			cfg_q.fat_copies           <= 8'd2;
			cfg_q.fat_sectors          <= 16'd9;
			cfg_q.root_entry_limit     <= 16'd224;
			cfg_q.volume_sectors       <= 16'd2880;
		end else if (cfg_write) begin
			case (ffcc_pkg::cfg_idx_t'(cfg_index))
				ffcc_pkg::CFG_SECTOR_LOG2:  cfg_q.sector_bytes_log2    <= cfg_data[3:0];
				ffcc_pkg::CFG_CLUSTER_LOG2: cfg_q.cluster_sectors_log2 <= cfg_data[2:0];
				ffcc_pkg::CFG_RESERVED:     cfg_q.reserved_count       <= cfg_data;
				ffcc_pkg::CFG_FAT_COPIES:   cfg_q.fat_copies           <= cfg_data[7:0];
				ffcc_pkg::CFG_FAT_SECTORS:  cfg_q.fat_sectors          <= cfg_data;
				ffcc_pkg::CFG_ROOT_LIMIT:   cfg_q.root_entry_limit     <= cfg_data;
				ffcc_pkg::CFG_VOL_SECTORS:  cfg_q.volume_sectors       <= cfg_data;
				default: ;
			endcase
		end
	end

	ffcc_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.geom   (geom)
	);

	// Only a final byte needs the result register; other bytes wait only behind a held final byte.
	assign out_free = !out_valid_q || !out_stall;
	assign s2_move  = !v_s2 || !last_s2 || out_free;
	assign en1      = !v_s1 || s2_move;
	assign in_stall = !en1;
	assign take     = v_s2 && s2_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (s2_move) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			byte_s1 <= table_byte;
			last_s1 <= final_byte;
		end
		if (s2_move) begin
			byte_s2 <= byte_s1;
			last_s2 <= last_s1;
		end
	end

	ffcc_tally u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.table_byte (byte_s2),
		.final_byte (last_s2),
		.geom       (geom),
		.tally_next (tally_next)
	);

	assign sl          = ffcc_pkg::clamp_sl(cfg_q.sector_bytes_log2);
	assign shift_total = {1'b0, sl} + {2'b0, cfg_q.cluster_sectors_log2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s2) begin
			free_clusters_q <= tally_next;
			free_bytes_q    <= {19'b0, tally_next} << shift_total;
			cluster_count_q <= geom.clusters;
			twelve_q        <= geom.twelve_bit;
			disk_bytes_q    <= {12'b0, cfg_q.volume_sectors} << sl;
		end
	end

	assign out_valid        = out_valid_q;
	assign free_clusters    = free_clusters_q;
	assign free_bytes       = free_bytes_q;
	assign cluster_count    = cluster_count_q;
	assign twelve_bit_table = twelve_q;
	assign disk_bytes       = disk_bytes_q;

endmodule

// File: rtl/core/ffcc_checker.sv
// ----------------------------------------------------------------------------
// ffcc_checker
// Port-level checks of the free-cluster counter, bound to the top level.
// ----------------------------------------------------------------------------
module ffcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] free_clusters,
	input logic [34:0] free_bytes,
	input logic [15:0] cluster_count,
	input logic        twelve_bit_table,
	input logic [27:0] disk_bytes
);

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(free_clusters))
		else $error("result dropped or changed while stalled");

	a_width_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (twelve_bit_table == (cluster_count <= ffcc_pkg::FAT12_LIMIT)))
		else $error("table width disagrees with cluster count");

	// sector is at least 512 bytes
	a_disk_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (disk_bytes[8:0] == 9'd0) && (free_bytes[8:0] == 9'd0))
		else $error("byte counts not sector aligned");

	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (free_clusters == 16'd0) |-> (free_bytes == 35'd0))
		else $error("free bytes without free clusters");

endmodule

bind fat_free_cluster_counter_unit ffcc_checker u_ffcc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.free_clusters    (free_clusters),
	.free_bytes       (free_bytes),
	.cluster_count    (cluster_count),
	.twelve_bit_table (twelve_bit_table),
	.disk_bytes       (disk_bytes)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams FAT12 and FAT16 tables through the free-cluster counter under many
// volume geometries, predicts every volume total in the bench and compares
// each reported total field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [2:0] CFG_IDX_SPARE = 3'd7;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct {
		logic [15:0] free_clusters;
		logic [34:0] free_bytes;
		logic [15:0] cluster_count;
		logic        twelve_bit;
		logic [27:0] disk_bytes;
	} volume_totals_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  table_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] free_clusters;
	logic [34:0] free_bytes;
	logic [15:0] cluster_count;
	logic        twelve_bit_table;
	logic [27:0] disk_bytes;

	// bench copy of the geometry registers and the counter state
	ffcc_pkg::cfg_t   volume_geom;
	ffcc_pkg::phase_t fill_phase;
	logic [7:0]  held_lo;
	logic [7:0]  held_mid;
	logic [16:0] next_entry;
	logic [15:0] free_tally;

	volume_totals_t expected_totals[$];

	bit gaps_on  = 1'b1;
	bit stall_on = 1'b1;
	int errors         = 0;
	int bytes_sent     = 0;
	int totals_checked = 0;
	int settings_used  = 0;

	fat_free_cluster_counter_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.table_byte       (table_byte),
		.final_byte       (final_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.free_clusters    (free_clusters),
		.free_bytes       (free_bytes),
		.cluster_count    (cluster_count),
		.twelve_bit_table (twelve_bit_table),
		.disk_bytes       (disk_bytes)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic int effective_sector_shift();
		int shift;
		shift = int'(volume_geom.sector_bytes_log2);
		if (shift < 9) shift = 9;
		if (shift > 12) shift = 12;
		return shift;
	endfunction

	function automatic logic [15:0] count_clusters();
		int unsigned shift;
		longint unsigned root_sec;
		longint unsigned used;
		longint unsigned data_sec;
		shift = effective_sector_shift();
		root_sec = ((longint'(volume_geom.root_entry_limit) << ffcc_pkg::DIR_ENTRY_LOG2)
			+ (64'd1 << shift) - 1) >> shift;
		used = longint'(volume_geom.reserved_count)
			+ longint'(volume_geom.fat_copies) * longint'(volume_geom.fat_sectors) + root_sec;
		data_sec = (used >= volume_geom.volume_sectors) ? 0 : volume_geom.volume_sectors - used;
		return 16'(data_sec >> volume_geom.cluster_sectors_log2);
	endfunction

	function automatic void tally_entry(input logic [15:0] value, input logic [15:0] clusters);
		if (value == 16'd0 && next_entry >= 17'd2 &&
				18'(next_entry) < 18'(clusters) + 18'd2 && free_tally != ffcc_pkg::TALLY_MAX)
			free_tally++;
		if (next_entry != ffcc_pkg::POS_MAX)
			next_entry++;
	endfunction

	function automatic void clear_counters();
		fill_phase = ffcc_pkg::PH_EMPTY;
		held_lo    = 8'd0;
		held_mid   = 8'd0;
		next_entry = 17'd0;
		free_tally = 16'd0;
	endfunction

	function automatic void predict_byte(input logic [7:0] value, input logic last);
		logic [15:0]    clusters;
		logic           twelve;
		int             shift;
		volume_totals_t totals;
		clusters = count_clusters();
		twelve = clusters <= ffcc_pkg::FAT12_LIMIT;
		if (twelve) begin
			case (fill_phase)
				ffcc_pkg::PH_EMPTY: begin
					held_lo = value;
					fill_phase = ffcc_pkg::PH_ONE;
				end
				ffcc_pkg::PH_ONE: begin
					held_mid = value;
					fill_phase = ffcc_pkg::PH_TWO;
				end
				default: begin
					tally_entry({4'd0, held_mid[3:0], held_lo}, clusters);
					tally_entry({4'd0, value, held_mid[7:4]}, clusters);
					fill_phase = ffcc_pkg::PH_EMPTY;
				end
			endcase
		end else begin
			// a group left at two bytes by a width change closes on this byte
			if (fill_phase == ffcc_pkg::PH_EMPTY) begin
				held_lo = value;
				fill_phase = ffcc_pkg::PH_ONE;
			end else begin
				tally_entry({value, held_lo}, clusters);
				fill_phase = ffcc_pkg::PH_EMPTY;
			end
		end
		if (last) begin
			shift = effective_sector_shift();
			totals.free_clusters = free_tally;
			totals.free_bytes    = 35'(free_tally) << (shift + int'(volume_geom.cluster_sectors_log2));
			totals.cluster_count = clusters;
			totals.twelve_bit    = twelve;
			totals.disk_bytes    = 28'(volume_geom.volume_sectors) << shift;
			expected_totals.push_back(totals);
			clear_counters();
		end
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			ffcc_pkg::CFG_SECTOR_LOG2:  volume_geom.sector_bytes_log2    = value[3:0];
			ffcc_pkg::CFG_CLUSTER_LOG2: volume_geom.cluster_sectors_log2 = value[2:0];
			ffcc_pkg::CFG_RESERVED:     volume_geom.reserved_count       = value;
			ffcc_pkg::CFG_FAT_COPIES:   volume_geom.fat_copies           = value[7:0];
			ffcc_pkg::CFG_FAT_SECTORS:  volume_geom.fat_sectors          = value;
			ffcc_pkg::CFG_ROOT_LIMIT:   volume_geom.root_entry_limit     = value;
			ffcc_pkg::CFG_VOL_SECTORS:  volume_geom.volume_sectors       = value;
			default: ;
		endcase
	endtask

	task automatic program_geometry(input logic [3:0] sector_log2, input logic [2:0] cluster_log2,
			input logic [15:0] reserved, input logic [7:0] copies, input logic [15:0] fat_secs,
			input logic [15:0] root_limit, input logic [15:0] vol_secs);
		write_reg(ffcc_pkg::CFG_SECTOR_LOG2, {12'd0, sector_log2});
		write_reg(ffcc_pkg::CFG_CLUSTER_LOG2, {13'd0, cluster_log2});
		write_reg(ffcc_pkg::CFG_RESERVED, reserved);
		write_reg(ffcc_pkg::CFG_FAT_COPIES, {8'd0, copies});
		write_reg(ffcc_pkg::CFG_FAT_SECTORS, fat_secs);
		write_reg(ffcc_pkg::CFG_ROOT_LIMIT, root_limit);
		write_reg(ffcc_pkg::CFG_VOL_SECTORS, vol_secs);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	task automatic push_table_byte(input logic [7:0] value, input logic last);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		table_byte <= value;
		final_byte <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_byte(value, last);
		bytes_sent++;
	endtask

	task automatic push_stream(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			push_table_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// wait out every pending total plus the pipeline before touching registers
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] random_table_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) return 8'h00;
		if (pick == 5) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic pick_random_geometry();
		int sl;
		int cl;
		int rsv;
		int copies;
		int fats;
		int root;
		int used;
		case ($urandom_range(0, 3))
			0: program_geometry(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
				16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			1: begin
				// tiny data area so streams run past the last cluster
				sl = $urandom_range(9, 12);
				cl = $urandom_range(0, 3);
				rsv = $urandom_range(0, 8);
				copies = $urandom_range(1, 2);
				fats = $urandom_range(0, 12);
				root = $urandom_range(0, 32);
				used = rsv + copies * fats + ((root * 32 + (1 << sl) - 1) >> sl);
				program_geometry(4'(sl), 3'(cl), 16'(rsv), 8'(copies), 16'(fats), 16'(root),
					16'(used + ($urandom_range(0, 24) << cl)));
			end
			2: program_geometry(4'd9, 3'd0, 16'd1, 8'd2, 16'($urandom_range(0, 200)), 16'd512,
				16'($urandom_range(5000, 65535)));
			default: program_geometry(4'd9, 3'd0, 16'd0, 8'd1, 16'd0, 16'd0,
				16'($urandom_range(4083, 4086)));
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_floppy_defaults();
		// reset geometry is a FAT12 floppy; nibble split across the middle byte
		push_stream('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hF0, 8'h0F});
		settle_block();
	endtask

	task automatic test_fat16_entries();
		program_geometry(4'd9, 3'd0, 16'd0, 8'd1, 16'd0, 16'd0, 16'hFFFF);
		// odd length: the last entry never completes
		push_stream('{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00});
		settle_block();
	endtask

	task automatic test_empty_data_area();
		program_geometry(4'd9, 3'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_table_byte(8'hFF, 1'b1);
		settle_block();
	endtask

	task automatic test_sector_size_clamp();
		program_geometry(4'd0, 3'd7, 16'd0, 8'd1, 16'd0, 16'd0, 16'hFFFF);
		push_table_byte(8'h00, 1'b1);
		settle_block();
		program_geometry(4'd15, 3'd7, 16'd0, 8'd1, 16'd0, 16'd0, 16'hFFFF);
		push_table_byte(8'h00, 1'b1);
		settle_block();
	endtask

	task automatic test_spare_register();
		write_reg(CFG_IDX_SPARE, 16'hFFFF);
		cfg_write <= 1'b0;
		push_table_byte(8'h00, 1'b1);
		settle_block();
	endtask

	task automatic test_width_switch_midstream();
		program_geometry(4'd9, 3'd0, 16'd1, 8'd2, 16'd9, 16'd224, 16'd2880);
		// two FAT12 entries, then one byte held when the width flips to 16 bits
		push_table_byte(8'h00, 1'b0);
		push_table_byte(8'h00, 1'b0);
		push_table_byte(8'h00, 1'b0);
		push_table_byte(8'h00, 1'b0);
		settle_block();
		program_geometry(4'd9, 3'd0, 16'd0, 8'd1, 16'd0, 16'd0, 16'hFFFF);
		push_table_byte(8'h00, 1'b1);
		settle_block();
	endtask

	task automatic test_full_small_table();
		int total;
		// 40 clusters, all free, stream runs two entries past the last one
		program_geometry(4'd9, 3'd0, 16'd0, 8'd1, 16'd0, 16'd0, 16'd40);
		gaps_on = 1'b0;
		total = 66;
		for (int i = 1; i <= total; i++)
			push_table_byte(8'h00, i == total);
		settle_block();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_streams();
		int random_bytes;
		int length;
		random_bytes = 0;
		while (random_bytes < 800) begin
			gaps_on  = random_bytes < 700 && $urandom_range(0, 3) != 0;
			stall_on = random_bytes < 700 && $urandom_range(0, 3) != 0;
			pick_random_geometry();
			repeat ($urandom_range(1, 6)) begin
				length = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160)
					: $urandom_range(1, 48);
				for (int i = 1; i <= length; i++)
					push_table_byte(random_table_byte(), i == length);
				random_bytes += length;
			end
			// sometimes leave a stream open across the next register change
			if ($urandom_range(0, 3) == 0) begin
				length = $urandom_range(1, 5);
				repeat (length) push_table_byte(random_table_byte(), 1'b0);
				random_bytes += length;
			end
			settle_block();
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_field(input string label, input logic [34:0] want,
			input logic [34:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		volume_totals_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_totals.size() == 0) begin
				$display("%0t ns: unexpected transaction, expected none, actual free_clusters %0h",
					$time, free_clusters);
				errors++;
			end else begin
				want = expected_totals.pop_front();
				report_field("free_clusters", 35'(want.free_clusters), 35'(free_clusters));
				report_field("free_bytes", want.free_bytes, free_bytes);
				report_field("cluster_count", 35'(want.cluster_count), 35'(cluster_count));
				report_field("twelve_bit_table", 35'(want.twelve_bit), 35'(twelve_bit_table));
				report_field("disk_bytes", 35'(want.disk_bytes), 35'(disk_bytes));
				totals_checked++;
			end
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= 3'd0;
		cfg_data   <= 16'd0;
		in_valid   <= 1'b0;
		table_byte <= 8'd0;
		final_byte <= 1'b0;
		volume_geom = '{4'd9, 3'd0, 16'd1, 8'd2, 16'd9, 16'd224, 16'd2880};
		clear_counters();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_floppy_defaults();
		test_fat16_entries();
		test_empty_data_area();
		test_sector_size_clamp();
		test_spare_register();
		test_width_switch_midstream();
		test_full_small_table();
		test_random_streams();

		$display("Streamed %0d FAT bytes under %0d register settings, FAT12 and FAT16.",
			bytes_sent, settings_used);
		$display("Checked %0d volume totals, %0d field mismatches.", totals_checked, errors);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d totals still pending", expected_totals.size());
		$display("tb_top failed");
		$finish;
	end

endmodule
